// ===== src/phfe_pkg.sv =====
// ----------------------------------------------------------------------------
// phfe_pkg
// types and constants shared by the header field extractor modules
// ----------------------------------------------------------------------------
package phfe_pkg;

	localparam logic [15:0] ET_VLAN = 16'h8100;
	localparam logic [15:0] ET_IPV4 = 16'h0800;
	localparam logic [15:0] ET_IPV6 = 16'h86dd;

	localparam logic [11:0] VLAN_MASK = 12'h0fff;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [3:0] IP_VERSION_4 = 4'd4;
	localparam logic [3:0] MIN_HDR_WORDS = 4'd5;

	localparam logic [7:0] ETH_HDR_LEN  = 8'd14;
	localparam logic [7:0] VLAN_HDR_LEN = 8'd18;
	localparam logic [7:0] POS_MAX      = 8'd255;

	localparam logic [2:0] ST_TCP_UDP    = 3'd0;
	localparam logic [2:0] ST_IPV4_OTHER = 3'd1;
	localparam logic [2:0] ST_BAD_IP     = 3'd2;
	localparam logic [2:0] ST_IPV6       = 3'd3;
	localparam logic [2:0] ST_OTHER_TYPE = 3'd4;
	localparam logic [2:0] ST_TRUNCATED  = 3'd5;
	localparam logic [2:0] ST_NOT_PARSED = 3'd6;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_packet;
	} in_item_t;

	typedef struct packed {
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [11:0] vlan_id;
		logic [7:0]  ip_proto;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  payload_offset;
		logic [2:0]  status;
	} out_item_t;

	// byte tagged with its position in the frame
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_packet;
		logic [7:0] pos;
	} tagged_byte_t;

endpackage

// ===== src/phfe_front.sv =====
// ----------------------------------------------------------------------------
// phfe_front
// input side: accepts frame bytes and tags each with its frame position
// ----------------------------------------------------------------------------
module phfe_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  phfe_pkg::in_item_t    in_data,
	input  logic                  q_full,
	output logic                  push,
	output phfe_pkg::tagged_byte_t push_item
);

	logic [7:0] pos_q;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	assign push_item.data_byte     = in_data.data_byte;
	assign push_item.end_of_packet = in_data.end_of_packet;
	assign push_item.pos           = pos_q;

	// position saturates and restarts after the last byte of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (in_data.end_of_packet) begin
				pos_q <= '0;
			end else if (pos_q != phfe_pkg::POS_MAX) begin
				pos_q <= pos_q + 8'd1;
			end
		end
	end

endmodule

// ===== src/phfe_queue.sv =====
// ----------------------------------------------------------------------------
// phfe_queue
// short fifo of tagged bytes between the front and back ends
// ----------------------------------------------------------------------------
module phfe_queue #(
	parameter int DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  phfe_pkg::tagged_byte_t push_item,
	output logic                   full,
	input  logic                   pop,
	output phfe_pkg::tagged_byte_t pop_item,
	output logic                   empty
);

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	phfe_pkg::tagged_byte_t mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full     = (count_q == FullCnt);
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

// ===== src/phfe_back.sv =====
// ----------------------------------------------------------------------------
// phfe_back
// back end: header field capture per byte and result register per packet
// ----------------------------------------------------------------------------
module phfe_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   parse_enable,
	input  logic                   q_empty,
	input  phfe_pkg::tagged_byte_t q_item,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output phfe_pkg::out_item_t    out_data
);

	typedef enum logic [4:0] {
		PH_ETH  = 5'b00001,
		PH_VLAN = 5'b00010,
		PH_IP   = 5'b00100,
		PH_L4   = 5'b01000,
		PH_DONE = 5'b10000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] eth_type;
		logic [3:0]  ihl;
		logic [3:0]  ver;
		logic [7:0]  l4_start;
		logic [3:0]  tcp_words;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [11:0] vlan;
		logic [7:0]  proto;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  payload_start;
	} parse_state_t;

	localparam parse_state_t PsIdle = '{phase: PH_ETH, default: '0};

	parse_state_t        ps_q;
	parse_state_t        ps_d;
	phfe_pkg::out_item_t out_q;
	logic                out_valid_q;
	phfe_pkg::out_item_t res;

	logic [7:0]  pos;
	logic [7:0]  b;
	logic [7:0]  r;
	logic [7:0]  q;
	logic [15:0] et_shift;
	logic [3:0]  ip_words;
	logic [3:0]  tcp_words;
	logic [8:0]  len;
	logic [8:0]  l4x;
	logic [8:0]  need;
	logic        bad_ip;

	assign pos = q_item.pos;
	assign b   = q_item.data_byte;

	// a result byte waits until the output register is free
	assign pop = !q_empty && (!q_item.end_of_packet || !out_valid_q || !out_stall);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// field capture for one byte
	always_comb begin
		ps_d     = ps_q;
		r        = pos - ps_q.payload_start;
		q        = pos - ps_q.l4_start;
		et_shift = {ps_q.eth_type[7:0], b};
		ip_words = (ps_q.ihl < phfe_pkg::MIN_HDR_WORDS) ? phfe_pkg::MIN_HDR_WORDS : ps_q.ihl;
		case (ps_q.phase)
			PH_ETH: begin
				if (pos < 8'd6) begin
					ps_d.dst_mac = {ps_q.dst_mac[39:0], b};
				end else if (pos < 8'd12) begin
					ps_d.src_mac = {ps_q.src_mac[39:0], b};
				end else if (pos < 8'd14) begin
					ps_d.eth_type = et_shift;
				end
				if (pos == 8'd13) begin
					if (et_shift == phfe_pkg::ET_VLAN) begin
						ps_d.phase = PH_VLAN;
					end else begin
						ps_d.payload_start = phfe_pkg::ETH_HDR_LEN;
						ps_d.phase = (et_shift == phfe_pkg::ET_IPV4) ? PH_IP : PH_DONE;
					end
				end
			end
			PH_VLAN: begin
				if (pos < 8'd16) begin
					ps_d.vlan = {ps_q.vlan[3:0], b} & phfe_pkg::VLAN_MASK;
				end else if (pos < 8'd18) begin
					ps_d.eth_type = et_shift;
				end
				if (pos == 8'd17) begin
					ps_d.payload_start = phfe_pkg::VLAN_HDR_LEN;
					ps_d.phase = (et_shift == phfe_pkg::ET_IPV4) ? PH_IP : PH_DONE;
				end
			end
			PH_IP: begin
				if (r == 8'd0) begin
					ps_d.ver = b[7:4];
					ps_d.ihl = b[3:0];
				end else if (r == 8'd9) begin
					ps_d.proto = b;
				end else if (r >= 8'd12 && r < 8'd16) begin
					ps_d.src_ip = {ps_q.src_ip[23:0], b};
				end else if (r >= 8'd16 && r < 8'd20) begin
					ps_d.dst_ip = {ps_q.dst_ip[23:0], b};
				end
				if (r == 8'd19) begin
					ps_d.l4_start = ps_q.payload_start + {2'b00, ip_words, 2'b00};
					ps_d.phase = PH_L4;
				end
			end
			PH_L4: begin
				if (pos >= ps_q.l4_start) begin
					if (q < 8'd2) begin
						ps_d.src_port = {ps_q.src_port[7:0], b};
					end else if (q < 8'd4) begin
						ps_d.dst_port = {ps_q.dst_port[7:0], b};
					end else if (q == 8'd12) begin
						ps_d.tcp_words = b[7:4];
					end
				end
			end
			default: begin
				ps_d = ps_q;
			end
		endcase
	end

	// packet result from the state after the last byte
	always_comb begin
		res       = '0;
		len       = {1'b0, pos} + 9'd1;
		l4x       = {1'b0, ps_d.l4_start};
		tcp_words = (ps_d.tcp_words < phfe_pkg::MIN_HDR_WORDS) ?
			phfe_pkg::MIN_HDR_WORDS : ps_d.tcp_words;
		bad_ip    = (ps_d.ver != phfe_pkg::IP_VERSION_4) || (ps_d.src_ip == '0) ||
			(ps_d.dst_ip == '0);
		if (ps_d.proto == phfe_pkg::PROTO_TCP) begin
			need = (len < l4x + 9'd20) ? l4x + 9'd20 : l4x + {3'b000, tcp_words, 2'b00};
		end else if (ps_d.proto == phfe_pkg::PROTO_UDP) begin
			need = l4x + 9'd8;
		end else begin
			need = l4x;
		end
		if (!parse_enable) begin
			res.status = phfe_pkg::ST_NOT_PARSED;
		end else begin
			case (ps_d.phase)
				PH_DONE: begin
					res.status = (ps_d.eth_type == phfe_pkg::ET_IPV6) ?
						phfe_pkg::ST_IPV6 : phfe_pkg::ST_OTHER_TYPE;
					res.dst_mac        = ps_d.dst_mac;
					res.src_mac        = ps_d.src_mac;
					res.vlan_id        = ps_d.vlan;
					res.payload_offset = ps_d.payload_start;
				end
				PH_L4: begin
					if (bad_ip) begin
						res.status         = phfe_pkg::ST_BAD_IP;
						res.dst_mac        = ps_d.dst_mac;
						res.src_mac        = ps_d.src_mac;
						res.vlan_id        = ps_d.vlan;
						res.payload_offset = ps_d.payload_start;
					end else if (len < need) begin
						res.status = phfe_pkg::ST_TRUNCATED;
					end else begin
						res.dst_mac        = ps_d.dst_mac;
						res.src_mac        = ps_d.src_mac;
						res.vlan_id        = ps_d.vlan;
						res.payload_offset = need[7:0];
						res.ip_proto       = ps_d.proto;
						res.src_ip         = ps_d.src_ip;
						res.dst_ip         = ps_d.dst_ip;
						if (ps_d.proto == phfe_pkg::PROTO_TCP ||
							ps_d.proto == phfe_pkg::PROTO_UDP) begin
							res.status   = phfe_pkg::ST_TCP_UDP;
							res.src_port = ps_d.src_port;
							res.dst_port = ps_d.dst_port;
						end else begin
							res.status = phfe_pkg::ST_IPV4_OTHER;
						end
					end
				end
				default: begin
					res.status = phfe_pkg::ST_TRUNCATED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q <= PsIdle;
		end else if (pop) begin
			if (q_item.end_of_packet) begin
				ps_q <= PsIdle;
			end else begin
				ps_q <= ps_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && q_item.end_of_packet) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_item.end_of_packet) begin
			out_q <= res;
		end
	end

endmodule

// ===== src/packet_header_field_extractor_core.sv =====
// ----------------------------------------------------------------------------
// packet_header_field_extractor_core
// ethernet / vlan / ipv4 / tcp-udp header field extractor, one byte per cycle
// ----------------------------------------------------------------------------
// Takes a frame one byte per transfer and gives one result per frame, on its
// end_of_packet byte. One byte is accepted every clock cycle unless the fifo
// is full; the front end tags each byte with its frame position and writes it
// into a QUEUE_DEPTH entry fifo, and the back end captures header fields one
// byte per cycle unless the fifo is empty or a result waits on out_stall. A
// result is in the output register at the edge that takes its last byte from
// the fifo. While a result waits the back end holds only its next end_of_packet
// byte, and the fifo keeps taking bytes until it is full. parse_enable resets
// to 1; the user writes it through cfg_wr_en / cfg_wr_data only while idle,
// which the block does not enforce. QUEUE_DEPTH must be at least 2.
module packet_header_field_extractor_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  phfe_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output phfe_pkg::out_item_t out_data
);

	logic                   parse_enable_q;
	logic                   push;
	logic                   pop;
	logic                   q_full;
	logic                   q_empty;
	phfe_pkg::tagged_byte_t push_item;
	phfe_pkg::tagged_byte_t pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_enable_q <= 1'b1;
		end else if (cfg_wr_en) begin
			parse_enable_q <= cfg_wr_data;
		end
	end

	phfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	phfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	phfe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.parse_enable (parse_enable_q),
		.q_empty      (q_empty),
		.q_item       (pop_item),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data)
	);

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for packet_header_field_extractor_core
// ----------------------------------------------------------------------------
// Frames go in one byte per transfer, from a queue that the stimulus process
// fills. A byte-level tracker predicts the header result of each frame on
// its end_of_packet byte, and every result that leaves the core is checked
// field by field against the oldest prediction. Directed frames cover each
// header case and truncation point. Random frames are mostly well formed
// with random content, mixed with noise and cut frames. Both sides idle at
// random, the receiver holds off once for a long stretch, and parse_enable
// is switched between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam int LONG_STALL   = 300;
	localparam int MAX_REPORTS  = 100;

	typedef logic [7:0] byte_q_t[$];
	typedef enum logic [2:0] {PHASE_ETH, PHASE_VLAN, PHASE_IP, PHASE_L4, PHASE_DONE} hdr_phase_e;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic                cfg_wr_data = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	phfe_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	phfe_pkg::out_item_t out_data;

	phfe_pkg::in_item_t  frame_bytes[$];
	phfe_pkg::out_item_t expected_headers[$];
	int                  queued_bytes = 0;
	int                  error_count = 0;
	int                  cycle_count = 0;
	int                  tx_idle_pct = 0;
	int                  rx_idle_pct = 0;
	int                  long_stall_requests = 0;
	int                  long_stall_seen = 0;
	int                  long_stall_left = 0;

	// header tracker state
	logic        parse_enabled;
	int unsigned hdr_pos, hdr_l3_start, hdr_l4_start;
	hdr_phase_e  hdr_phase;
	logic [15:0] hdr_ethertype;
	logic [3:0]  hdr_ihl, hdr_version, hdr_tcp_words;
	logic [47:0] hdr_dst_mac, hdr_src_mac;
	logic [11:0] hdr_vlan;
	logic [7:0]  hdr_proto;
	logic [31:0] hdr_src_ip, hdr_dst_ip;
	logic [15:0] hdr_src_port, hdr_dst_port;

	packet_header_field_extractor_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic clear_header_state();
		hdr_pos = 0;
		hdr_phase = PHASE_ETH;
		hdr_ethertype = '0;
		hdr_ihl = '0;
		hdr_version = '0;
		hdr_l3_start = 0;
		hdr_l4_start = 0;
		hdr_tcp_words = '0;
		hdr_dst_mac = '0;
		hdr_src_mac = '0;
		hdr_vlan = '0;
		hdr_proto = '0;
		hdr_src_ip = '0;
		hdr_dst_ip = '0;
		hdr_src_port = '0;
		hdr_dst_port = '0;
	endtask

	task automatic enter_l3(input int unsigned start);
		hdr_l3_start = start;
		hdr_phase = (hdr_ethertype == phfe_pkg::ET_IPV4) ? PHASE_IP : PHASE_DONE;
	endtask

	task automatic track_header_byte(input phfe_pkg::in_item_t item);
		int unsigned         pos, rel, words, need, frame_len;
		logic [7:0]          b;
		phfe_pkg::out_item_t res;
		b = item.data_byte;
		pos = hdr_pos;
		case (hdr_phase)
			PHASE_ETH: begin
				if (pos < 6) hdr_dst_mac = {hdr_dst_mac[39:0], b};
				else if (pos < 12) hdr_src_mac = {hdr_src_mac[39:0], b};
				else if (pos < 14) hdr_ethertype = {hdr_ethertype[7:0], b};
				if (pos == 13) begin
					if (hdr_ethertype == phfe_pkg::ET_VLAN) hdr_phase = PHASE_VLAN;
					else enter_l3(phfe_pkg::ETH_HDR_LEN);
				end
			end
			PHASE_VLAN: begin
				if (pos < 16) hdr_vlan = {hdr_vlan[3:0], b} & phfe_pkg::VLAN_MASK;
				else if (pos < 18) hdr_ethertype = {hdr_ethertype[7:0], b};
				if (pos == 17) enter_l3(phfe_pkg::VLAN_HDR_LEN);
			end
			PHASE_IP: begin
				rel = pos - hdr_l3_start;
				if (rel == 0) begin
					hdr_version = b[7:4];
					hdr_ihl = b[3:0];
				end else if (rel == 9) begin
					hdr_proto = b;
				end else if (rel >= 12 && rel < 16) begin
					hdr_src_ip = {hdr_src_ip[23:0], b};
				end else if (rel >= 16 && rel < 20) begin
					hdr_dst_ip = {hdr_dst_ip[23:0], b};
				end
				if (rel == 19) begin
					words = (hdr_ihl < phfe_pkg::MIN_HDR_WORDS) ?
						phfe_pkg::MIN_HDR_WORDS : hdr_ihl;
					hdr_l4_start = hdr_l3_start + words * 4;
					hdr_phase = PHASE_L4;
				end
			end
			PHASE_L4: if (pos >= hdr_l4_start) begin
				rel = pos - hdr_l4_start;
				if (rel < 2) hdr_src_port = {hdr_src_port[7:0], b};
				else if (rel < 4) hdr_dst_port = {hdr_dst_port[7:0], b};
				else if (rel == 12) hdr_tcp_words = b[7:4];
			end
			default: ;
		endcase
		if (hdr_pos < phfe_pkg::POS_MAX) hdr_pos++;
		if (item.end_of_packet) begin
			frame_len = pos + 1;
			res = '0;
			if (!parse_enabled) begin
				res.status = phfe_pkg::ST_NOT_PARSED;
			end else if (hdr_phase == PHASE_ETH || hdr_phase == PHASE_VLAN ||
					hdr_phase == PHASE_IP) begin
				res.status = phfe_pkg::ST_TRUNCATED;
			end else if (hdr_phase == PHASE_DONE || hdr_version != phfe_pkg::IP_VERSION_4 ||
					hdr_src_ip == '0 || hdr_dst_ip == '0) begin
				if (hdr_phase == PHASE_DONE)
					res.status = (hdr_ethertype == phfe_pkg::ET_IPV6) ?
						phfe_pkg::ST_IPV6 : phfe_pkg::ST_OTHER_TYPE;
				else
					res.status = phfe_pkg::ST_BAD_IP;
				res.dst_mac = hdr_dst_mac;
				res.src_mac = hdr_src_mac;
				res.vlan_id = hdr_vlan;
				res.payload_offset = 8'(hdr_l3_start);
			end else begin
				if (hdr_proto == phfe_pkg::PROTO_TCP) begin
					words = (hdr_tcp_words < phfe_pkg::MIN_HDR_WORDS) ?
						phfe_pkg::MIN_HDR_WORDS : hdr_tcp_words;
					need = (frame_len < hdr_l4_start + 20) ? hdr_l4_start + 20
						: hdr_l4_start + words * 4;
					res.status = phfe_pkg::ST_TCP_UDP;
				end else if (hdr_proto == phfe_pkg::PROTO_UDP) begin
					need = hdr_l4_start + 8;
					res.status = phfe_pkg::ST_TCP_UDP;
				end else begin
					need = hdr_l4_start;
					res.status = phfe_pkg::ST_IPV4_OTHER;
				end
				if (frame_len < need) begin
					res.status = phfe_pkg::ST_TRUNCATED;
				end else begin
					res.dst_mac = hdr_dst_mac;
					res.src_mac = hdr_src_mac;
					res.vlan_id = hdr_vlan;
					res.ip_proto = hdr_proto;
					res.src_ip = hdr_src_ip;
					res.dst_ip = hdr_dst_ip;
					if (res.status == phfe_pkg::ST_TCP_UDP) begin
						res.src_port = hdr_src_port;
						res.dst_port = hdr_dst_port;
					end
					res.payload_offset = 8'(need);
				end
			end
			expected_headers.push_back(res);
			clear_header_state();
		end
	endtask

	task automatic check_field(input string name, input logic [47:0] want, input logic [47:0] got);
		if (got !== want) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	task automatic check_header_result(input phfe_pkg::out_item_t got);
		phfe_pkg::out_item_t want;
		if (expected_headers.size() == 0) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: result with nothing expected, expected none, got %h", $time, got);
			return;
		end
		want = expected_headers.pop_front();
		check_field("dst_mac", want.dst_mac, got.dst_mac);
		check_field("src_mac", want.src_mac, got.src_mac);
		check_field("vlan_id", want.vlan_id, got.vlan_id);
		check_field("ip_proto", want.ip_proto, got.ip_proto);
		check_field("src_ip", want.src_ip, got.src_ip);
		check_field("dst_ip", want.dst_ip, got.dst_ip);
		check_field("src_port", want.src_port, got.src_port);
		check_field("dst_port", want.dst_port, got.dst_port);
		check_field("payload_offset", want.payload_offset, got.payload_offset);
		check_field("status", want.status, got.status);
	endtask

	// byte driver
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			track_header_byte(in_data);
		if (!in_valid || !in_stall) begin
			if (arst_n && frame_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= frame_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver stall
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			check_header_result(out_data);
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (long_stall_left != 0) begin
			out_stall <= 1'b1;
			long_stall_left <= long_stall_left - 1;
		end else if (long_stall_seen != long_stall_requests) begin
			long_stall_seen <= long_stall_requests;
			long_stall_left <= LONG_STALL;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, expected_headers.size());
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic send_frame(input byte_q_t f);
		phfe_pkg::in_item_t item;
		foreach (f[k]) begin
			item.data_byte = f[k];
			item.end_of_packet = (k == f.size() - 1);
			frame_bytes.push_back(item);
		end
		queued_bytes += f.size();
	endtask

	task automatic queue_frame(input bit vlan_tag, input logic [15:0] etype,
			input logic [3:0] ver, input logic [3:0] ihl, input logic [7:0] proto,
			input logic [31:0] sip, input logic [31:0] dip, input logic [3:0] tcpw,
			input int payload, input int cut);
		byte_q_t f;
		int      k;
		repeat (12) f.push_back(8'($urandom));
		if (vlan_tag) begin
			f.push_back(phfe_pkg::ET_VLAN[15:8]);
			f.push_back(phfe_pkg::ET_VLAN[7:0]);
			repeat (2) f.push_back(8'($urandom));
		end
		f.push_back(etype[15:8]);
		f.push_back(etype[7:0]);
		if (etype == phfe_pkg::ET_IPV4) begin
			f.push_back({ver, ihl});
			repeat (8) f.push_back(8'($urandom));
			f.push_back(proto);
			repeat (2) f.push_back(8'($urandom));
			for (k = 24; k >= 0; k -= 8) f.push_back(sip[k +: 8]);
			for (k = 24; k >= 0; k -= 8) f.push_back(dip[k +: 8]);
			if (ihl > phfe_pkg::MIN_HDR_WORDS)
				repeat ((int'(ihl) - 5) * 4) f.push_back(8'($urandom));
			if (proto == phfe_pkg::PROTO_TCP) begin
				repeat (12) f.push_back(8'($urandom));
				f.push_back({tcpw, 4'($urandom)});
				repeat (7) f.push_back(8'($urandom));
				if (tcpw > phfe_pkg::MIN_HDR_WORDS)
					repeat ((int'(tcpw) - 5) * 4) f.push_back(8'($urandom));
			end else if (proto == phfe_pkg::PROTO_UDP) begin
				repeat (8) f.push_back(8'($urandom));
			end
		end
		repeat (payload) f.push_back(8'($urandom));
		while (cut != 0 && f.size() > cut) void'(f.pop_back());
		send_frame(f);
	endtask

	task automatic queue_random_frames(input int min_bytes, input int min_frames);
		int          start_bytes, frames, pick;
		logic [15:0] etype;
		logic [3:0]  ver, ihl, tcpw;
		logic [7:0]  proto;
		logic [31:0] sip, dip;
		byte_q_t     noise;
		start_bytes = queued_bytes;
		frames = 0;
		while (queued_bytes - start_bytes < min_bytes || frames < min_frames) begin
			if ($urandom_range(99) < 15) begin
				noise.delete();
				repeat ($urandom_range(1, 40)) noise.push_back(8'($urandom));
				send_frame(noise);
			end else begin
				pick = $urandom_range(99);
				etype = (pick < 75) ? phfe_pkg::ET_IPV4 : (pick < 83) ? phfe_pkg::ET_IPV6 :
					(pick < 88) ? phfe_pkg::ET_VLAN : 16'($urandom);
				ver = ($urandom_range(99) < 90) ? phfe_pkg::IP_VERSION_4 : 4'($urandom);
				ihl = ($urandom_range(99) < 70) ? phfe_pkg::MIN_HDR_WORDS : 4'($urandom);
				pick = $urandom_range(99);
				proto = (pick < 45) ? phfe_pkg::PROTO_TCP : (pick < 80) ? phfe_pkg::PROTO_UDP :
					8'($urandom);
				sip = ($urandom_range(99) < 5) ? 32'd0 : $urandom;
				dip = ($urandom_range(99) < 5) ? 32'd0 : $urandom;
				tcpw = ($urandom_range(99) < 70) ? phfe_pkg::MIN_HDR_WORDS : 4'($urandom);
				queue_frame($urandom_range(99) < 30, etype, ver, ihl, proto, sip, dip, tcpw,
					$urandom_range(12), ($urandom_range(99) < 15) ? $urandom_range(1, 60) : 0);
			end
			frames++;
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (frame_bytes.size() != 0 || in_valid || expected_headers.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_parse_enable(input logic value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		parse_enabled = value;
		@(negedge clk);
	endtask

	initial begin
		parse_enabled = 1'b1;
		clear_header_state();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed frames, sender idles a little, receiver a lot
		tx_idle_pct = 21;
		rx_idle_pct = 71;
		write_parse_enable(1'b1);
		queue_frame(0, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 5, phfe_pkg::PROTO_TCP,
			$urandom, $urandom, 5, 4, 0);
		queue_frame(1, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 5, phfe_pkg::PROTO_UDP,
			'1, '1, 5, 0, 0);
		queue_frame(0, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 6, 8'd1,
			32'd1, 32'd1, 5, 3, 0);
		queue_frame(0, phfe_pkg::ET_IPV4, 4'd6, 5, phfe_pkg::PROTO_TCP,
			$urandom, $urandom, 5, 2, 0);
		queue_frame(1, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 5, phfe_pkg::PROTO_UDP,
			32'd0, $urandom, 5, 2, 0);
		queue_frame(0, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 5, phfe_pkg::PROTO_UDP,
			$urandom, 32'd0, 5, 2, 0);
		queue_frame(1, phfe_pkg::ET_IPV6, 4'd6, 0, 8'd0, 32'd0, 32'd0, 5, 0, 0);
		queue_frame(0, 16'h0806, 4'd0, 0, 8'd0, 32'd0, 32'd0, 5, 0, 0);
		queue_frame(1, phfe_pkg::ET_VLAN, 4'd0, 0, 8'd0, 32'd0, 32'd0, 5, 6, 0);
		queue_frame(0, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 2, phfe_pkg::PROTO_TCP,
			$urandom, $urandom, 3, 2, 0);
		queue_frame(1, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 15, phfe_pkg::PROTO_TCP,
			$urandom, $urandom, 15, 0, 0);
		// truncation at each header boundary
		queue_frame(0, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 5, phfe_pkg::PROTO_TCP,
			$urandom, $urandom, 5, 0, 1);
		queue_frame(0, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 5, phfe_pkg::PROTO_TCP,
			$urandom, $urandom, 5, 0, 5);
		queue_frame(0, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 5, phfe_pkg::PROTO_TCP,
			$urandom, $urandom, 5, 0, 14);
		queue_frame(1, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 5, phfe_pkg::PROTO_UDP,
			$urandom, $urandom, 5, 0, 16);
		queue_frame(0, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 5, phfe_pkg::PROTO_UDP,
			$urandom, $urandom, 5, 0, 25);
		queue_frame(0, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 8, phfe_pkg::PROTO_UDP,
			$urandom, $urandom, 5, 0, 40);
		queue_frame(0, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 5, phfe_pkg::PROTO_UDP,
			$urandom, $urandom, 5, 0, 38);
		queue_frame(0, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 5, phfe_pkg::PROTO_TCP,
			$urandom, $urandom, 10, 0, 50);
		queue_frame(0, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 5, phfe_pkg::PROTO_TCP,
			$urandom, $urandom, 10, 0, 60);
		// frame longer than the position counter
		queue_frame(0, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 5, phfe_pkg::PROTO_UDP,
			$urandom, $urandom, 5, 215, 0);
		wait_drained();

		// sender mostly idle, receiver mostly ready
		tx_idle_pct = 71;
		rx_idle_pct = 21;
		write_parse_enable(1'b0);
		queue_frame(0, phfe_pkg::ET_IPV4, phfe_pkg::IP_VERSION_4, 5, phfe_pkg::PROTO_TCP,
			$urandom, $urandom, 5, 0, 0);
		queue_frame(1, phfe_pkg::ET_IPV6, 4'd6, 0, 8'd0, 32'd0, 32'd0, 5, 3, 7);
		wait_drained();
		write_parse_enable(1'b1);
		queue_random_frames(0, 2);
		wait_drained();

		// no idling, with one long receiver hold-off at the start
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		long_stall_requests++;
		queue_random_frames(100, 2);
		wait_drained();

		if (error_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
